// ===== design/rdpe_pkg.sv =====
// rdpe_pkg: shared types, constants and the parameter encoding function
// for the robot drive packet encoder; no dependencies
`timescale 1ns / 1ps

package rdpe_pkg;

    localparam int unsigned NUM_WORDS = 4;
    localparam logic [9:0]  MAG_LIMIT = 10'd1000;
    localparam logic [1:0]  CHARGE_ON  = 2'd2;
    localparam logic [1:0]  CHARGE_OFF = 2'd1;
    // floor(x / 10) = (x * RECIP_TEN) >> 19 for any 16-bit x
    localparam logic [15:0] RECIP_TEN = 16'hCCCD;

    // classified command held in the queue between front and back
    typedef struct packed {
        logic [2:0]  robot_id;
        logic        prefix;
        logic        error;
        logic        last_robot;
        logic [15:0] word3;
        logic [15:0] word2;
        logic [15:0] word1;
        logic [15:0] word0;
    } rdpe_cmd_t;

    // twelve-bit code of one binary64 parameter: scale at bit 11, sign at
    // bit 10, truncated magnitude below
    function automatic logic [11:0] encode_param(input logic [63:0] bits);
        logic [10:0] expo;
        logic [51:0] frac;
        logic [52:0] mant;
        logic [5:0]  sh;
        logic [51:0] mask;
        logic [13:0] ipart;
        logic        rem_nz;
        logic        rem_ones;
        logic [29:0] prod;
        logic [10:0] quot;
        logic [13:0] tens;
        logic [3:0]  rem10;
        logic [10:0] scaled;
        logic        neg;
        logic        big;
        logic [9:0]  mag;
        begin
            expo = bits[62:52];
            frac = bits[51:0];
            mant = {1'b1, frac};
            // integer part and fraction bits, meaningful for 1 up to 16383
            sh       = 6'(11'd1075 - expo);
            mask     = (52'd1 << sh) - 52'd1;
            ipart    = 14'(mant >> sh);
            rem_nz   = (frac & mask) != 52'd0;
            rem_ones = (frac & mask) == mask;
            // integer part divided by ten with a reciprocal multiply
            prod  = {16'd0, ipart} * {14'd0, RECIP_TEN};
            quot  = prod[29:19];
            tens  = {quot, 3'b000} + {2'b00, quot, 1'b0};
            rem10 = 4'(ipart - tens);
            // the rounded product v*0.1 reaches the next integer only when v
            // is one ulp below a multiple of ten in the upper half of its binade
            scaled = quot + {10'd0, frac[51] & rem_ones & (rem10 == 4'd9)};
            neg = bits[63];
            big = 1'b0;
            mag = 10'd0;
            if (expo == 11'h7FF) begin
                if (frac != 52'd0) begin
                    // nan counts as zero
                    neg = 1'b0;
                end else begin
                    // infinity counts as +/-10000
                    big = 1'b1;
                    mag = MAG_LIMIT;
                end
            end else if (expo < 11'd1023) begin
                // below one: magnitude zero, sign kept except for zero itself
                neg = neg && ((expo != 11'd0) || (frac != 52'd0));
            end else if (expo > 11'd1036) begin
                // 16384 and up always clamps after scaling
                big = 1'b1;
                mag = MAG_LIMIT;
            end else if ((ipart > 14'd1000) || ((ipart == 14'd1000) && rem_nz)) begin
                big = 1'b1;
                mag = (scaled > {1'b0, MAG_LIMIT}) ? MAG_LIMIT : scaled[9:0];
            end else begin
                mag = ipart[9:0];
            end
            encode_param = {big, neg, mag};
        end
    endfunction

endpackage

// ===== design/rdpe_front.sv =====
// rdpe_front: accepts commands, encodes the four words, writes the queue
// depends on rdpe_pkg
`timescale 1ns / 1ps

module rdpe_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         robot_id,
    input  logic [3:0]         motion_kind,
    input  logic [63:0]        param_a,
    input  logic [63:0]        param_b,
    input  logic [63:0]        param_c,
    input  logic [63:0]        param_d,
    input  logic [7:0]         aux_bits,
    input  logic               charge_enable,
    input  logic               full_packet,
    input  logic               last_robot,
    output logic               q_valid,
    input  logic               q_ready,
    output rdpe_pkg::rdpe_cmd_t q_cmd
);

    rdpe_pkg::rdpe_cmd_t cmd_reg, cmd_next;
    logic                valid_reg;
    logic [1:0]          chg;

    assign in_ready = !valid_reg || q_ready;
    assign q_valid  = valid_reg;
    assign q_cmd    = cmd_reg;

    // classify and encode one beat
    always_comb begin
        chg = charge_enable ? rdpe_pkg::CHARGE_ON : rdpe_pkg::CHARGE_OFF;
        cmd_next.robot_id   = robot_id;
        cmd_next.prefix     = !full_packet;
        cmd_next.error      = aux_bits[7];
        cmd_next.last_robot = last_robot;
        cmd_next.word0 = {motion_kind, rdpe_pkg::encode_param(param_a)};
        cmd_next.word1 = {chg, 2'b00, rdpe_pkg::encode_param(param_b)};
        cmd_next.word2 = {aux_bits[3:0], rdpe_pkg::encode_param(param_c)};
        cmd_next.word3 = {1'b0, aux_bits[6:4], rdpe_pkg::encode_param(param_d)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_valid && in_ready) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

// ===== design/rdpe_back.sv =====
// rdpe_back: walks one queued command out as packet bytes
// depends on rdpe_pkg
`timescale 1ns / 1ps

module rdpe_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_ready,
    input  rdpe_pkg::rdpe_cmd_t q_cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_byte,
    output logic               last_item,
    output logic               last_pkt,
    output logic               err
);

    localparam logic [3:0] LAST_IDX = 4'(2 * rdpe_pkg::NUM_WORDS);

    rdpe_pkg::rdpe_cmd_t cur_reg;
    logic                busy_reg;
    logic [3:0]          idx_reg;
    logic                fin;
    logic [2:0]          wsel;

    // byte index 0 is the id prefix, 1..8 the words low byte first
    assign wsel = 3'(idx_reg - 4'd1);
    always_comb begin
        case (wsel[2:1])
            2'd0:    out_byte = wsel[0] ? cur_reg.word0[15:8] : cur_reg.word0[7:0];
            2'd1:    out_byte = wsel[0] ? cur_reg.word1[15:8] : cur_reg.word1[7:0];
            2'd2:    out_byte = wsel[0] ? cur_reg.word2[15:8] : cur_reg.word2[7:0];
            default: out_byte = wsel[0] ? cur_reg.word3[15:8] : cur_reg.word3[7:0];
        endcase
        if (cur_reg.error) out_byte = 8'd0;
        else if (idx_reg == 4'd0) out_byte = {5'd0, cur_reg.robot_id};
    end

    assign fin       = cur_reg.error || (idx_reg == LAST_IDX);
    assign out_valid = busy_reg;
    assign last_item = fin;
    assign last_pkt  = fin && cur_reg.last_robot;
    assign err       = cur_reg.error;
    assign q_ready   = !busy_reg || (out_ready && fin);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 4'd0;
        end else if (q_ready) begin
            busy_reg <= q_valid;
            idx_reg  <= (q_cmd.prefix || q_cmd.error) ? 4'd0 : 4'd1;
        end else if (out_ready) begin
            idx_reg <= idx_reg + 4'd1;
        end
        if (q_ready && q_valid) begin
            cur_reg <= q_cmd;
        end
    end

    // the error beat is always final
    a_err_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && cur_reg.error) |-> last_item)
        else $error("error beat not final");
    a_idx_rng: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> idx_reg <= LAST_IDX)
        else $error("byte index out of range");
    a_pkt_item: assert property (@(posedge aclk) disable iff (!aresetn)
        last_pkt |-> last_item)
        else $error("packet end without item end");

endmodule

// ===== design/robot_drive_packet_encoder.sv =====
// robot_drive_packet_encoder: top level, front encoder, back byte sender
// depends on rdpe_pkg, rdpe_front, rdpe_back
`timescale 1ns / 1ps

// Takes one robot command per beat and sends its packet one byte per cycle
// while the receiver is ready: an id byte for reduced packets, then four
// 16-bit words low byte first, or a single zero byte with the error flag
// when extra bits exceed 127. The encoder writes a one-entry queue, so the
// next command is taken while the byte sender works; a command's bytes come
// from the byte sender's register once its queue entry has moved into it.
module robot_drive_packet_encoder (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // robot_id[2:0] motion_kind[6:3] param_a..d[262:7] aux_bits[270:263]
    // charge_enable[271] full_packet[272], zero padded
    input  logic [279:0] s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_byte[7:0]
    output logic [7:0]   m_tdata,
    // last_of_item[0] error[1]
    output logic [1:0]   m_tuser,
    output logic         m_tlast
);

    logic                q_valid, q_ready;
    rdpe_pkg::rdpe_cmd_t q_cmd;

    rdpe_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .robot_id(s_tdata[2:0]), .motion_kind(s_tdata[6:3]),
        .param_a(s_tdata[70:7]), .param_b(s_tdata[134:71]),
        .param_c(s_tdata[198:135]), .param_d(s_tdata[262:199]),
        .aux_bits(s_tdata[270:263]), .charge_enable(s_tdata[271]),
        .full_packet(s_tdata[272]), .last_robot(s_tlast),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    rdpe_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_byte(m_tdata), .last_item(m_tuser[0]),
        .last_pkt(m_tlast), .err(m_tuser[1])
    );

endmodule

// ===== tb/robot_drive_packet_encoder_tb.sv =====
// robot_drive_packet_encoder_tb: self-checking bench for the drive packet encoder
// depends on robot_drive_packet_encoder (and rdpe_pkg through it)
`timescale 1ns / 1ps

module robot_drive_packet_encoder_tb;

    // one robot command as it travels on the input stream
    typedef struct {
        logic [2:0]  robot_id;
        logic [3:0]  motion_kind;
        logic [63:0] param [4];
        logic [7:0]  aux_bits;
        logic        charge_enable;
        logic        full_packet;
        logic        last_robot;
    } drive_cmd_t;

    // one packet byte with its flags
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_item;
        logic       last_of_packet;
        logic       error;
    } pkt_byte_t;

    logic         aclk;
    logic         aresetn = 1'b0;
    logic         s_tvalid;
    logic         s_tready;
    logic [279:0] s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [7:0]   m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    drive_cmd_t cmd_queue[$];
    pkt_byte_t  byte_queue[$];
    int         err_count = 0;
    int         cmds_sent = 0;
    int         bytes_seen = 0;
    int         burst_left;
    int         gap_left;
    int         stall_phase;
    bit         stim_done = 1'b0;

    robot_drive_packet_encoder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // twelve-bit code of one binary64 parameter, done in real arithmetic
    function automatic logic [11:0] param_code(input logic [63:0] bits);
        real        v;
        logic [11:0] w;
        begin
            w = 12'd0;
            if (bits[62:52] == 11'h7FF) begin
                if (bits[51:0] != 52'd0) v = 0.0;
                else v = bits[63] ? -10000.0 : 10000.0;
            end else begin
                v = $bitstoreal(bits);
            end
            if (v < 0.0) begin
                w[10] = 1'b1;
                v = -v;
            end
            if (v > 1000.0) begin
                w[11] = 1'b1;
                v = v * 0.1;
            end
            if (v > 1000.0) v = 1000.0;
            // truncation toward zero; v is below 1001 here
            w[9:0] = 10'($rtoi(v));
            param_code = w;
        end
    endfunction

    // expected packet bytes of one command
    task automatic predict_packet(input drive_cmd_t c);
        logic [15:0] words [4];
        pkt_byte_t   b;
        begin
            if (c.aux_bits > 8'd127) begin
                b = '{8'd0, 1'b1, c.last_robot, 1'b1};
                byte_queue.push_back(b);
            end else begin
                for (int i = 0; i < 4; i++) words[i] = {4'd0, param_code(c.param[i])};
                words[0][15:12] = c.motion_kind;
                words[1][15:14] = c.charge_enable ? 2'd2 : 2'd1;
                words[2][15:12] = c.aux_bits[3:0];
                words[3][15:12] = c.aux_bits[7:4];
                if (!c.full_packet)
                    byte_queue.push_back('{{5'd0, c.robot_id}, 1'b0, 1'b0, 1'b0});
                for (int i = 0; i < 4; i++) begin
                    byte_queue.push_back('{words[i][7:0], 1'b0, 1'b0, 1'b0});
                    byte_queue.push_back('{words[i][15:8], i == 3, (i == 3) & c.last_robot,
                                           1'b0});
                end
            end
        end
    endtask

    task automatic report(input string what, input int got, input int want);
        begin
            $display("mismatch at byte %0d: %s got %0h want %0h", bytes_seen, what, got, want);
            err_count++;
        end
    endtask

    // random binary64 pattern, mostly in the interesting ranges
    function automatic logic [63:0] rand_param();
        logic [63:0] r;
        begin
            r = {$urandom, $urandom};
            case ($urandom_range(0, 9))
                0: r[62:52] = 11'h7FF;
                1: r[62:52] = 11'd0;
                2, 3: r[62:52] = 11'($urandom_range(1015, 1040));
                4: r = $realtobits(($urandom_range(0, 1) ? -1.0 : 1.0) *
                                   real'($urandom_range(995, 1005)));
                5: r = $realtobits(($urandom_range(0, 1) ? -1.0 : 1.0) *
                                   real'($urandom_range(9990, 10010)));
                6: r = $realtobits(real'($urandom_range(0, 20000)) / 10.0 -
                                   real'($urandom_range(0, 1)) * 2000.0);
                // one ulp below a multiple of ten, where scaling rounds up
                7: r = $realtobits(10.0 * real'($urandom_range(101, 1001))) - 64'd1;
                default: ;
            endcase
            rand_param = r;
        end
    endfunction

    function automatic drive_cmd_t rand_cmd();
        drive_cmd_t c;
        begin
            c.robot_id      = 3'($urandom);
            c.motion_kind   = 4'($urandom);
            for (int i = 0; i < 4; i++) c.param[i] = rand_param();
            c.aux_bits      = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(128, 255))
                                                          : 8'($urandom_range(0, 127));
            c.charge_enable = 1'($urandom);
            c.full_packet   = 1'($urandom);
            c.last_robot    = 1'($urandom);
            rand_cmd = c;
        end
    endfunction

    // directed commands: special values, extremes, every flag; then random commands
    initial begin
        drive_cmd_t  c;
        logic [63:0] specials [16];
        specials = '{64'h7FF8000000000001, 64'h7FF0000000000000, 64'hFFF0000000000000,
                     64'h8000000000000000, 64'h0000000000000000, 64'hFFFFFFFFFFFFFFFF,
                     $realtobits(1000.0), $realtobits(1000.5), $realtobits(-1000.25),
                     $realtobits(10000.0), $realtobits(10009.9), $realtobits(-0.999),
                     $realtobits(1e300), 64'h0000000000000001, $realtobits(1023.99),
                     $realtobits(8191.5)};
        for (int k = 0; k < 20; k++) begin
            c = rand_cmd();
            for (int i = 0; i < 4; i++) c.param[i] = specials[(4 * k + i) % 16];
            c.motion_kind   = (k % 2) ? 4'hF : 4'h0;
            c.robot_id      = (k % 2) ? 3'd7 : 3'd0;
            c.aux_bits      = (k == 3) ? 8'd255 : (k == 4) ? 8'd128 : (k == 5) ? 8'd127
                              : 8'(k * 6);
            c.charge_enable = k[1];
            c.full_packet   = k[2];
            c.last_robot    = k[0];
            cmd_queue.push_back(c);
        end
        for (int k = 0; k < 500; k++) cmd_queue.push_back(rand_cmd());
    end

    // sender: bursts of random length with random gaps
    always @(posedge aclk) begin
        drive_cmd_t c;
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tlast    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) cmds_sent <= cmds_sent + 1;
            if (gap_left > 0) begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (cmd_queue.size() == 0) begin
                s_tvalid  <= 1'b0;
                stim_done <= 1'b1;
            end else begin
                c = cmd_queue.pop_front();
                predict_packet(c);
                s_tvalid <= 1'b1;
                s_tdata  <= {7'd0, c.full_packet, c.charge_enable, c.aux_bits,
                             c.param[3], c.param[2], c.param[1], c.param[0],
                             c.motion_kind, c.robot_id};
                s_tlast  <= c.last_robot;
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(0, 12);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end
            end
        end
    end

    // receiver: stall pattern cycles through free-running, sparse and random phases
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready    <= 1'b0;
            stall_phase <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            case ((stall_phase / 400) % 3)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= 1'($urandom);
            endcase
        end
    end

    // monitor: compare each accepted beat with the oldest expected byte
    always @(posedge aclk) begin
        pkt_byte_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (byte_queue.size() == 0) begin
                report("unexpected beat", m_tdata, 0);
            end else begin
                w = byte_queue.pop_front();
                if (m_tdata !== w.out_byte) report("out_byte", m_tdata, w.out_byte);
                if (m_tuser[0] !== w.last_of_item)
                    report("last_of_item", m_tuser[0], w.last_of_item);
                if (m_tuser[1] !== w.error) report("error", m_tuser[1], w.error);
                if (m_tlast !== w.last_of_packet)
                    report("last_of_packet", m_tlast, w.last_of_packet);
            end
            bytes_seen <= bytes_seen + 1;
        end
    end

    // reset, then wait for the packet stream to drain
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        wait (stim_done && byte_queue.size() == 0);
        repeat (50) @(posedge aclk);
        $display("sent %0d robot commands, checked %0d packet bytes", cmds_sent, bytes_seen);
        if (err_count == 0) $display("robot_drive_packet_encoder_tb: clean");
        else $display("robot_drive_packet_encoder_tb: errors");
        $finish;
    end

    // watchdog
    initial begin
        #400000;
        $display("robot_drive_packet_encoder_tb: errors");
        $finish;
    end

endmodule
